FILE: hdl/mcf_pkg.sv
// Shared types, constants and helpers for the multichannel FIR filter core.
// No dependencies; every other file imports this package.
`default_nettype none

package mcf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 22;
  localparam int IN_FIELDS  = 4;
  localparam int COEF_W     = 4;
  localparam int COEF_COUNT = 16;
  localparam int COEF_IDX_W = 4;
  localparam int MAX_TAPS   = 64;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  localparam coef_t COEFS [COEF_COUNT] = '{
    4'sd3,  -4'sd2,  4'sd5,  4'sd7,
    -4'sd1,  4'sd4, -4'sd3,  4'sd6,
    4'sd2,  -4'sd5,  4'sd1,  4'sd3,
    -4'sd4,  4'sd2,  4'sd6, -4'sd2
  };

  // Levels of a 4-input adder tree needed to reduce n terms to one.
  function automatic int clog4(int n);
    int lv;
    int span;
    lv   = 0;
    span = 1;
    while (span < n) begin
      span = span * 4;
      lv++;
    end
    return lv;
  endfunction

  localparam int MAX_STG = clog4(MAX_TAPS) + 1;

  // Pipeline control sent from the controller to every lane and the merge stage.
  typedef struct packed {
    logic               shift;     // input transfer: advance the delay line
    logic [MAX_STG-1:0] en;        // per-stage load enables (product, tree levels)
    logic               out_load;  // load the output register
  } lane_ctl_t;

  // Coefficient of tap k; taps past the table are zero.
  function automatic coef_t tap_coef(int k);
    if (k < COEF_COUNT) begin
      return COEFS[k[COEF_IDX_W-1:0]];
    end
    return '0;
  endfunction

  // Sample times coefficient, wrapped to the result width.
  function automatic sum_t coef_mult(sample_t x, coef_t c);
    sum_t xe;
    sum_t ce;
    xe = {{(SUM_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
    ce = {{(SUM_W-COEF_W){c[COEF_W-1]}}, c};
    return xe * ce;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mcf_ifs.sv
// Valid/ready stream interfaces for the frame input and the result output.
// Depends on mcf_pkg for sample and sum types.
`default_nettype none

interface mcf_in_if import mcf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_ch0;
  sample_t sample_ch1;
  sample_t sample_ch2;
  sample_t sample_ch3;

  modport source (output valid, output sample_ch0, output sample_ch1,
                  output sample_ch2, output sample_ch3, input ready);
  modport sink   (input valid, input sample_ch0, input sample_ch1,
                  input sample_ch2, input sample_ch3, output ready);
endinterface

interface mcf_out_if import mcf_pkg::*; ();
  logic valid;
  logic ready;
  sum_t sum_ch0;
  sum_t sum_ch1;
  sum_t sum_ch2;
  sum_t sum_ch3;

  modport source (output valid, output sum_ch0, output sum_ch1,
                  output sum_ch2, output sum_ch3, input ready);
  modport sink   (input valid, input sum_ch0, input sum_ch1,
                  input sum_ch2, input sum_ch3, output ready);
endinterface

`default_nettype wire

FILE: hdl/mcf_lane.sv
// One channel lane: tap delay line, constant-coefficient products and a
// registered 4-input adder tree. Depends on mcf_pkg.
`default_nettype none

module mcf_lane import mcf_pkg::*; #(
  parameter int NUM_TAPS = 16
) (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  sample_t   sample,
  output sum_t      sum
);

  localparam int HIST = NUM_TAPS - 1;
  localparam int LVLS = clog4(NUM_TAPS);
  localparam int PAD  = 4 ** LVLS;

  sample_t hist_r [HIST];
  sum_t    prod   [PAD];
  sum_t    tree_r [LVLS+1][PAD];

  // Shift the delay line on every input transfer, newest sample in slot 0.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hist_r[0] <= sample;
      for (int j = 1; j < HIST; j++) begin
        hist_r[j] <= hist_r[j-1];
      end
    end
  end

  for (genvar k = 0; k < PAD; k++) begin : g_prod
    if (k == 0) begin : g_cur
      assign prod[k] = coef_mult(sample, tap_coef(0));
    end else if (k < NUM_TAPS) begin : g_old
      assign prod[k] = coef_mult(hist_r[k-1], tap_coef(k));
    end else begin : g_pad
      assign prod[k] = '0;
    end
  end

  // Level 0 holds the products; each later level sums groups of four.
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      for (int k = 0; k < PAD; k++) begin
        tree_r[0][k] <= prod[k];
      end
    end
    for (int l = 1; l <= LVLS; l++) begin
      if (ctl.en[l]) begin
        for (int j = 0; j < PAD / 4; j++) begin
          if (j < (PAD >> (2 * l))) begin
            tree_r[l][j] <= tree_r[l-1][4*j]   + tree_r[l-1][4*j+1]
                          + tree_r[l-1][4*j+2] + tree_r[l-1][4*j+3];
          end
        end
      end
    end
  end

  assign sum = tree_r[LVLS][0];

endmodule

`default_nettype wire

FILE: hdl/mcf_ctrl.sv
// Pipeline controller: fill count, per-stage valid bits and stall-aware
// load enables shared by all lanes. Depends on mcf_pkg.
`default_nettype none

module mcf_ctrl import mcf_pkg::*; #(
  parameter int NUM_TAPS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output lane_ctl_t ctl
);

  localparam int STG   = clog4(NUM_TAPS) + 1;
  localparam int HIST  = NUM_TAPS - 1;
  localparam int CNT_W = $clog2(NUM_TAPS);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [STG-1:0]   vld_r, vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [STG:0]     en;
  logic             full;
  logic             accept;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[STG] = !out_vld_r || out_ready;
    for (int i = STG - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  // Hold off input transfers while in reset.
  assign full   = (fill_r == CNT_W'(HIST));
  assign accept = in_valid && en[0] && rst_n;

  always_comb begin
    vld_nxt[0] = en[0] ? (accept && full) : vld_r[0];
    for (int i = 1; i < STG; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
    out_vld_nxt = en[STG] ? vld_r[STG-1] : out_vld_r;
    fill_nxt    = (accept && !full) ? fill_r + CNT_W'(1) : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign ctl.shift    = accept;
  assign ctl.en       = MAX_STG'(en[STG-1:0]);
  assign ctl.out_load = en[STG];
  assign in_ready     = en[0] && rst_n;
  assign out_valid    = out_vld_r;

  a_fill_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !full |=> !vld_r[0])
    else $error("frame taken during fill produced a result");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(HIST))
    else $error("fill count past history depth");

  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> fill_r >= $past(fill_r))
    else $error("fill count went down outside reset");

  a_last_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready && vld_r[STG-1] |-> !en[STG-1])
    else $error("last tree stage overwritten while output stalled");

endmodule

`default_nettype wire

FILE: hdl/mcf_merge.sv
// Merge stage: output register that gathers the lane sums into one result.
// Depends on mcf_pkg.
`default_nettype none

module mcf_merge import mcf_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  sum_t      lane_sum [LANES],
  output sum_t      sum_out  [IN_FIELDS]
);

  sum_t sum_r [LANES];

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      for (int c = 0; c < LANES; c++) begin
        sum_r[c] <= lane_sum[c];
      end
    end
  end

  // Fields without a lane read zero.
  for (genvar c = 0; c < IN_FIELDS; c++) begin : g_out
    if (c < LANES) begin : g_used
      assign sum_out[c] = sum_r[c];
    end else begin : g_unused
      assign sum_out[c] = '0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/multichannel_fir_filter_core.sv
// Top level of the multichannel FIR filter: one lane per channel, shared
// controller and merge stage. Depends on mcf_pkg, mcf_ifs, mcf_lane,
// mcf_ctrl and mcf_merge.
//
//   Channel   Dir   Handshake     Payload
//   in_chan   in    valid/ready   sample_ch0..sample_ch3, 16-bit signed each
//   out_chan  out   valid/ready   sum_ch0..sum_ch3, 22-bit signed each
//
// Throughput: one frame transfer per clock in steady state, while the output is not stalled.
// Pipeline: clog4(NUM_TAPS)+2 register stages (4 at 16 taps): product register,
//   adder-tree levels, output register. out_valid rises once a frame's result
//   has passed through all of them into the output register.
// The first NUM_TAPS-1 frames after reset only fill the delay lines and give
//   no result. Reset is synchronous, active low, and clears control state only.
// A stalled output holds its result; stages behind it keep loading into any
//   empty slot, so input transfers go on until the pipeline is full.
`default_nettype none

module multichannel_fir_filter_core import mcf_pkg::*; #(
  parameter int NUM_TAPS     = 16,
  parameter int NUM_CHANNELS = 4
) (
  input  logic clk,
  input  logic rst_n,
  mcf_in_if.sink    in_chan,
  mcf_out_if.source out_chan
);

  // Channels past the input fields carry only zero samples and are never
  // emitted, so build lanes for the visible channels alone.
  localparam int LANES = (NUM_CHANNELS < IN_FIELDS) ? NUM_CHANNELS : IN_FIELDS;

  lane_ctl_t ctl;
  sample_t   in_sample [IN_FIELDS];
  sum_t      lane_sum  [LANES];
  sum_t      sum_out   [IN_FIELDS];

  assign in_sample[0] = in_chan.sample_ch0;
  assign in_sample[1] = in_chan.sample_ch1;
  assign in_sample[2] = in_chan.sample_ch2;
  assign in_sample[3] = in_chan.sample_ch3;

  // Valid bits, fill count and per-stage load enables.
  mcf_ctrl #(
    .NUM_TAPS (NUM_TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .ctl       (ctl)
  );

  // One filter lane per channel, all stepping together.
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    mcf_lane #(
      .NUM_TAPS (NUM_TAPS)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .sample (in_sample[c]),
      .sum    (lane_sum[c])
    );
  end

  // Gather the lane sums into the output register.
  mcf_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .ctl      (ctl),
    .lane_sum (lane_sum),
    .sum_out  (sum_out)
  );

  assign out_chan.sum_ch0 = sum_out[0];
  assign out_chan.sum_ch1 = sum_out[1];
  assign out_chan.sum_ch2 = sum_out[2];
  assign out_chan.sum_ch3 = sum_out[3];

endmodule

`default_nettype wire
